// ===== sv/rrss_pkg.sv =====
package rrss_pkg;

    localparam int TIME_W = 21;
    localparam int ID_W   = 5;
    localparam int VAL_W  = 16;

    typedef struct packed {
        logic load_start;
        logic shift_step;
        logic shift_place;
        logic sched_start;
        logic scan_step;
        logic push_skip;
        logic pop;
        logic exec;
        logic jump_step;
        logic out_load;
        logic out_step;
        logic clear;
    } rrss_cmd_t;

    typedef struct packed {
        logic full;
        logic in_last;
        logic pend_last;
        logic loaded_zero;
        logic shift_more;
        logic scan_last;
        logic skip_vld;
        logic all_done;
        logic fifo_empty;
        logic jump_hit;
        logic out_last;
    } rrss_sts_t;

endpackage

// ===== sv/rrss_ctrl.sv =====
module rrss_ctrl
    import rrss_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  logic      m_tready,
    input  rrss_sts_t sts,
    output rrss_cmd_t cmd
);

    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_SHIFT = 4'd1;
    localparam logic [3:0] S_START = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_PUSH  = 4'd4;
    localparam logic [3:0] S_DISP  = 4'd5;
    localparam logic [3:0] S_EXEC  = 4'd6;
    localparam logic [3:0] S_JUMP  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;
    localparam logic [3:0] S_OWAIT = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_tready = (state_reg == S_LOAD);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_LOAD: begin
                if (s_tvalid) begin
                    if (sts.full) begin
                        if (sts.in_last && !sts.loaded_zero) state_next = S_START;
                    end else begin
                        cmd.load_start = 1'b1;
                        state_next     = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                if (sts.shift_more) begin
                    cmd.shift_step = 1'b1;
                end else begin
                    cmd.shift_place = 1'b1;
                    state_next      = sts.pend_last ? S_START : S_LOAD;
                end
            end
            S_START: begin
                cmd.sched_start = 1'b1;
                state_next      = S_SCAN;
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last) state_next = sts.skip_vld ? S_PUSH : S_DISP;
            end
            S_PUSH: begin
                cmd.push_skip = 1'b1;
                state_next    = S_DISP;
            end
            S_DISP: begin
                if (sts.all_done) begin
                    state_next = S_OUT;
                end else if (sts.fifo_empty) begin
                    state_next = S_JUMP;
                end else begin
                    cmd.pop    = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = S_SCAN;
            end
            S_JUMP: begin
                cmd.jump_step = 1'b1;
                if (sts.jump_hit) state_next = S_SCAN;
            end
            S_OUT: begin
                cmd.out_load = 1'b1;
                state_next   = S_OWAIT;
            end
            S_OWAIT: begin
                if (m_tready) begin
                    cmd.out_step = 1'b1;
                    if (sts.out_last) begin
                        cmd.clear  = 1'b1;
                        state_next = S_LOAD;
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_LOAD;
        else          state_reg <= state_next;
    end

endmodule

// ===== sv/rrss_dp.sv =====
module rrss_dp
    import rrss_pkg::*;
#(
    parameter int MAX_PROCS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [VAL_W-1:0]   arrival_time,
    input  logic [VAL_W-1:0]   burst_time,
    input  logic               last_process,
    input  logic [VAL_W-1:0]   time_quantum,
    input  rrss_cmd_t          cmd,
    output rrss_sts_t          sts,
    output logic               m_tvalid,
    output logic [ID_W-1:0]    process_id,
    output logic [TIME_W-1:0]  completion_time,
    output logic [TIME_W-1:0]  turnaround_time,
    output logic [TIME_W-1:0]  waiting_time,
    output logic               last_result
);

    localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW = $clog2(MAX_PROCS + 1);

    logic [VAL_W-1:0]  arr_rf  [MAX_PROCS];
    logic [VAL_W-1:0]  bur_rf  [MAX_PROCS];
    logic [VAL_W-1:0]  rem_rf  [MAX_PROCS];
    logic [ID_W-1:0]   id_rf   [MAX_PROCS];
    logic [TIME_W-1:0] comp_rf [MAX_PROCS];
    logic [IW-1:0]     fifo_rf [MAX_PROCS];

    logic [MAX_PROCS-1:0] fin_reg;
    logic [MAX_PROCS-1:0] qd_reg;

    logic [VAL_W-1:0]  a_reg;
    logic [VAL_W-1:0]  b_reg;
    logic              pend_last_reg;
    logic [CW-1:0]     pos_reg;
    logic [CW-1:0]     loaded_reg;
    logic [CW-1:0]     done_reg;
    logic [CW-1:0]     j_reg;
    logic [CW-1:0]     k_reg;
    logic [IW-1:0]     skip_reg;
    logic              skip_vld_reg;
    logic [IW-1:0]     i_reg;
    logic [IW-1:0]     head_reg;
    logic [CW-1:0]     cnt_reg;
    logic [TIME_W-1:0] cur_reg;
    logic              mvalid_reg;
    logic [ID_W-1:0]   oid_reg;
    logic [TIME_W-1:0] ocomp_reg;
    logic [TIME_W-1:0] otat_reg;
    logic [TIME_W-1:0] owait_reg;
    logic              olast_reg;

    logic [CW-1:0]     pm1;
    logic [IW-1:0]     pix;
    logic [IW-1:0]     pm1ix;
    logic [IW-1:0]     jix;
    logic [IW-1:0]     kix;
    logic [CW:0]       tsum;
    logic [CW:0]       tail;
    logic [IW-1:0]     tix;
    logic [IW-1:0]     hd_item;
    logic [VAL_W-1:0]  qe;
    logic [VAL_W-1:0]  rem_i;
    logic [TIME_W-1:0] arr_j;
    logic              scan_push;
    logic [TIME_W-1:0] tat_c;

    assign pm1    = pos_reg - 1'b1;
    assign pix    = pos_reg[IW-1:0];
    assign pm1ix  = pm1[IW-1:0];
    assign jix    = j_reg[IW-1:0];
    assign kix    = k_reg[IW-1:0];
    assign tsum   = (CW+1)'(head_reg) + (CW+1)'(cnt_reg);
    assign tail   = (tsum >= (CW+1)'(MAX_PROCS)) ? tsum - (CW+1)'(MAX_PROCS) : tsum;
    assign tix    = tail[IW-1:0];
    assign hd_item = fifo_rf[head_reg];
    assign qe     = (time_quantum == '0) ? VAL_W'(1) : time_quantum;
    assign rem_i  = rem_rf[i_reg];
    assign arr_j  = TIME_W'(arr_rf[jix]);
    assign scan_push = ((jix != skip_reg) || !skip_vld_reg) && !fin_reg[jix] && !qd_reg[jix]
                       && (arr_j <= cur_reg);
    assign tat_c  = comp_rf[kix] - TIME_W'(arr_rf[kix]);

    assign sts.full        = (loaded_reg == CW'(MAX_PROCS));
    assign sts.in_last     = last_process;
    assign sts.pend_last   = pend_last_reg;
    assign sts.loaded_zero = (loaded_reg == '0);
    assign sts.shift_more  = (pos_reg != '0) && (arr_rf[pm1ix] > a_reg);
    assign sts.scan_last   = (j_reg == loaded_reg - 1'b1);
    assign sts.skip_vld    = skip_vld_reg;
    assign sts.all_done    = (done_reg == loaded_reg);
    assign sts.fifo_empty  = (cnt_reg == '0);
    assign sts.jump_hit    = !fin_reg[jix];
    assign sts.out_last    = olast_reg;

    assign m_tvalid        = mvalid_reg;
    assign process_id      = oid_reg;
    assign completion_time = ocomp_reg;
    assign turnaround_time = otat_reg;
    assign waiting_time    = owait_reg;
    assign last_result     = olast_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_start) begin
            a_reg <= arrival_time;
            b_reg <= burst_time;
        end
        if (cmd.shift_step) begin
            arr_rf[pix] <= arr_rf[pm1ix];
            bur_rf[pix] <= bur_rf[pm1ix];
            rem_rf[pix] <= rem_rf[pm1ix];
            id_rf[pix]  <= id_rf[pm1ix];
        end
        if (cmd.shift_place) begin
            arr_rf[pix] <= a_reg;
            bur_rf[pix] <= b_reg;
            rem_rf[pix] <= b_reg;
            id_rf[pix]  <= ID_W'(loaded_reg + 1'b1);
        end
        if (cmd.scan_step && scan_push && cnt_reg < CW'(MAX_PROCS)) fifo_rf[tix] <= jix;
        if (cmd.push_skip && cnt_reg < CW'(MAX_PROCS)) fifo_rf[tix] <= skip_reg;
        if (cmd.pop) i_reg <= hd_item;
        if (cmd.exec) begin
            if (rem_i <= qe) begin
                rem_rf[i_reg]  <= '0;
                comp_rf[i_reg] <= cur_reg + TIME_W'(rem_i);
            end else begin
                rem_rf[i_reg] <= rem_i - qe;
            end
            skip_reg <= i_reg;
        end
        if (cmd.out_load) begin
            oid_reg   <= id_rf[kix];
            ocomp_reg <= comp_rf[kix];
            otat_reg  <= tat_c;
            owait_reg <= tat_c - TIME_W'(bur_rf[kix]);
            olast_reg <= (k_reg == loaded_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            fin_reg       <= '0;
            qd_reg        <= '0;
            pend_last_reg <= 1'b0;
            pos_reg       <= '0;
            loaded_reg    <= '0;
            done_reg      <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            skip_vld_reg  <= 1'b0;
            head_reg      <= '0;
            cnt_reg       <= '0;
            cur_reg       <= '0;
            mvalid_reg    <= 1'b0;
        end else begin
            if (cmd.load_start) begin
                pend_last_reg <= last_process;
                pos_reg       <= loaded_reg;
            end
            if (cmd.shift_step) pos_reg <= pm1;
            if (cmd.shift_place) loaded_reg <= loaded_reg + 1'b1;
            if (cmd.sched_start) begin
                cur_reg      <= TIME_W'(arr_rf[0]);
                j_reg        <= '0;
                skip_vld_reg <= 1'b0;
            end
            if (cmd.scan_step) begin
                j_reg <= sts.scan_last ? '0 : j_reg + 1'b1;
                if (scan_push && cnt_reg < CW'(MAX_PROCS)) begin
                    cnt_reg     <= cnt_reg + 1'b1;
                    qd_reg[jix] <= 1'b1;
                end
            end
            if (cmd.push_skip) begin
                skip_vld_reg <= 1'b0;
                if (cnt_reg < CW'(MAX_PROCS)) begin
                    cnt_reg          <= cnt_reg + 1'b1;
                    qd_reg[skip_reg] <= 1'b1;
                end
            end
            if (cmd.pop) begin
                head_reg        <= (head_reg == IW'(MAX_PROCS - 1)) ? '0 : head_reg + 1'b1;
                cnt_reg         <= cnt_reg - 1'b1;
                qd_reg[hd_item] <= 1'b0;
            end
            if (cmd.exec) begin
                j_reg <= '0;
                if (rem_i <= qe) begin
                    cur_reg        <= cur_reg + TIME_W'(rem_i);
                    fin_reg[i_reg] <= 1'b1;
                    done_reg       <= done_reg + 1'b1;
                    skip_vld_reg   <= 1'b0;
                end else begin
                    cur_reg      <= cur_reg + TIME_W'(qe);
                    skip_vld_reg <= 1'b1;
                end
            end
            if (cmd.jump_step) begin
                if (!fin_reg[jix]) begin
                    if (arr_j > cur_reg) cur_reg <= arr_j;
                    j_reg        <= '0;
                    skip_vld_reg <= 1'b0;
                end else begin
                    j_reg <= j_reg + 1'b1;
                end
            end
            if (cmd.out_load) mvalid_reg <= 1'b1;
            if (cmd.out_step) begin
                mvalid_reg <= 1'b0;
                k_reg      <= k_reg + 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_PROCS))
        else $error("ready queue count above capacity");
    a_done_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg <= loaded_reg)
        else $error("more completions than loaded processes");
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> cnt_reg != '0)
        else $error("pop from empty ready queue");
    a_out_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> done_reg == loaded_reg)
        else $error("result issued before all processes finished");
`endif

endmodule

// ===== sv/round_robin_schedule_sim_unit.sv =====
// Round-robin scheduling simulator.
// Input channel s_*: one process per transfer, tdata = {burst_time, arrival_time},
// tlast marks the final process of a set and starts the run. Each process is
// inserted in arrival order by shifting one entry per cycle. A process arriving
// while MAX_PROCS are held is dropped.
// Config channel cfg_*: time quantum, written by the user only while the block
// is idle; the block itself does not enforce this. 0 acts as 1.
// Scheduling rescans the n held processes at the start and after each slice; a
// preempted process rejoins the queue after the rescan, and an empty queue
// leads to a jump to the next arrival. s_tready is low meanwhile.
// Result channel m_*: one result per process in arrival order; tlast marks the
// last. A stalled receiver holds the result and the block waits. After the last
// transfer the block is empty and takes a new set.
// Reset (aresetn low, synchronous) empties the table and sets the quantum to 4.
module round_robin_schedule_sim_unit
    import rrss_pkg::*;
#(
    parameter int MAX_PROCS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // arrival_time[15:0], burst_time[31:16]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // process_id[4:0], completion_time[25:5],
                                   // turnaround_time[46:26], waiting_time[67:47]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    rrss_cmd_t         cmd;
    rrss_sts_t         sts;
    logic [15:0]       quantum_reg;
    logic [ID_W-1:0]   pid;
    logic [TIME_W-1:0] comp;
    logic [TIME_W-1:0] tat;
    logic [TIME_W-1:0] wt;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn)       quantum_reg <= 16'd4;
        else if (cfg_valid) quantum_reg <= cfg_data;
    end

    rrss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rrss_dp #(.MAX_PROCS(MAX_PROCS)) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .arrival_time    (s_tdata[15:0]),
        .burst_time      (s_tdata[31:16]),
        .last_process    (s_tlast),
        .time_quantum    (quantum_reg),
        .cmd             (cmd),
        .sts             (sts),
        .m_tvalid        (m_tvalid),
        .process_id      (pid),
        .completion_time (comp),
        .turnaround_time (tat),
        .waiting_time    (wt),
        .last_result     (m_tlast)
    );

    assign m_tdata = {4'b0, wt, tat, comp, pid};

endmodule

// ===== verif/round_robin_schedule_sim_unit_test.sv =====
module round_robin_schedule_sim_unit_test;
    import rrss_pkg::*;

    localparam int NPROC = 16;

    typedef struct {
        logic [ID_W-1:0]   pid;
        logic [TIME_W-1:0] completion;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic              last;
    } sched_result_t;

    class sched_scoreboard;
        logic [15:0]       quantum;
        logic [15:0]       arr_tab[NPROC];
        logic [15:0]       burst_tab[NPROC];
        int unsigned       left_tab[NPROC];
        logic [ID_W-1:0]   id_tab[NPROC];
        int unsigned       done_at[NPROC];
        bit                done_flag[NPROC];
        bit                queued_flag[NPROC];
        int unsigned       ready_q[$];
        int unsigned       held;
        int unsigned       clock_now;
        sched_result_t     expected_q[$];
        int                errors;

        function new();
            quantum = 16'd4;
            held = 0;
            errors = 0;
        endfunction

        function void admit(int unsigned skip);
            for (int unsigned j = 0; j < held; j++) begin
                if (j != skip && !done_flag[j] && !queued_flag[j] && arr_tab[j] <= clock_now
                    && ready_q.size() < NPROC) begin
                    ready_q.push_back(j);
                    queued_flag[j] = 1;
                end
            end
        endfunction

        function void schedule();
            int unsigned q, finished, i;
            sched_result_t r;
            q = (quantum == 0) ? 1 : 32'(quantum);
            finished = 0;
            for (int j = 0; j < NPROC; j++) begin
                done_flag[j] = 0;
                queued_flag[j] = 0;
            end
            ready_q.delete();
            clock_now = 32'(arr_tab[0]);
            admit(held);
            while (finished < held) begin
                if (ready_q.size() == 0) begin
                    for (int unsigned j = 0; j < held; j++) begin
                        if (!done_flag[j]) begin
                            if (arr_tab[j] > clock_now) clock_now = 32'(arr_tab[j]);
                            break;
                        end
                    end
                    admit(held);
                    continue;
                end
                i = ready_q.pop_front();
                queued_flag[i] = 0;
                if (left_tab[i] <= q) begin
                    clock_now += left_tab[i];
                    left_tab[i] = 0;
                    done_at[i] = clock_now;
                    done_flag[i] = 1;
                    finished++;
                    admit(held);
                end else begin
                    clock_now += q;
                    left_tab[i] -= q;
                    admit(i);
                    if (ready_q.size() < NPROC) begin
                        ready_q.push_back(i);
                        queued_flag[i] = 1;
                    end
                end
            end
            for (int unsigned k = 0; k < held; k++) begin
                r.pid = id_tab[k];
                r.completion = TIME_W'(done_at[k]);
                r.turnaround = TIME_W'(done_at[k] - arr_tab[k]);
                r.waiting = TIME_W'(done_at[k] - arr_tab[k] - burst_tab[k]);
                r.last = (k + 1 == held);
                expected_q.push_back(r);
            end
            held = 0;
        endfunction

        function void note_process(logic [15:0] arr, logic [15:0] burst, logic last);
            int unsigned pos;
            if (held < NPROC) begin
                pos = held;
                while (pos > 0 && arr_tab[pos-1] > arr) begin
                    arr_tab[pos] = arr_tab[pos-1];
                    burst_tab[pos] = burst_tab[pos-1];
                    left_tab[pos] = left_tab[pos-1];
                    id_tab[pos] = id_tab[pos-1];
                    pos--;
                end
                arr_tab[pos] = arr;
                burst_tab[pos] = burst;
                left_tab[pos] = 32'(burst);
                id_tab[pos] = ID_W'(held + 1);
                held++;
            end
            if (last && held > 0) schedule();
        endfunction

        function void check_result(logic [71:0] data, logic last);
            sched_result_t e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result data=%h last=%b", $time, data, last);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (data[4:0] !== e.pid) begin
                $display("%0t: process_id exp %0d got %0d", $time, e.pid, data[4:0]);
                errors++;
            end
            if (data[25:5] !== e.completion) begin
                $display("%0t: completion exp %0d got %0d", $time, e.completion, data[25:5]);
                errors++;
            end
            if (data[46:26] !== e.turnaround) begin
                $display("%0t: turnaround exp %0d got %0d", $time, e.turnaround,
                         data[46:26]);
                errors++;
            end
            if (data[67:47] !== e.waiting) begin
                $display("%0t: waiting exp %0d got %0d", $time, e.waiting, data[67:47]);
                errors++;
            end
            if (last !== e.last) begin
                $display("%0t: tlast exp %b got %b", $time, e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [71:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    sched_scoreboard sb = new();
    bit calm = 0;
    int sent = 0;

    round_robin_schedule_sim_unit #(.MAX_PROCS(NPROC)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
            m_tready <= calm || ($urandom_range(0, 99) >= 19);
        end
    end

    task automatic send_process(input logic [15:0] arr, input logic [15:0] burst,
                                input logic last);
        while (!calm && $urandom_range(0, 99) < 19) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {burst, arr};
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_process(arr, burst, last);
        sent++;
    endtask

    task automatic settle();
        s_tvalid <= 0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_quantum(input logic [15:0] q);
        settle();
        cfg_valid <= 1;
        cfg_data <= q;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        sb.quantum = q;
    endtask

    task automatic random_set();
        int n, cap, base, ofs;
        logic [15:0] arr;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 18) : $urandom_range(1, 16);
        cap = ((sb.quantum == 0) ? 1 : int'(sb.quantum)) * 6;
        if (cap > 65535) cap = 65535;
        base = $urandom_range(0, 65535);
        for (int k = 0; k < n; k++) begin
            ofs = $urandom_range(0, 40);
            if ($urandom_range(0, 3) == 0) arr = 16'($urandom_range(0, 65535));
            else arr = (base + ofs > 65535) ? 16'hFFFF : 16'(base + ofs);
            send_process(arr, ($urandom_range(0, 9) == 0) ? 16'd0
                                                           : 16'($urandom_range(1, cap)),
                         k == n - 1);
        end
    endtask

    initial begin
        logic [15:0] qset[5];
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        send_process(16'd5, 16'd3, 0);
        send_process(16'd0, 16'd10, 0);
        send_process(16'd5, 16'd0, 0);
        send_process(16'd100, 16'd7, 1);
        for (int k = 0; k < 18; k++)
            send_process(16'(k % 5), 16'(k + 1), k == 17);
        write_quantum(16'hFFFF);
        send_process(16'hFFFF, 16'hFFFF, 0);
        send_process(16'd0, 16'hFFFF, 1);

        qset = '{16'd0, 16'd1, 16'hFFFF, 16'($urandom_range(2, 65535)),
                 16'($urandom_range(2, 20))};
        for (int ph = 0; ph < 5; ph++) begin
            write_quantum(qset[ph]);
            calm = (ph == 2);
            while (sent < 24 + 16 * (ph + 1)) random_set();
        end
        calm = 0;
        settle();
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("round_robin_schedule_sim_unit_test OK");
        else
            $display("round_robin_schedule_sim_unit_test NOT OK");
        $finish;
    end

    initial begin
        #20000000;
        $display("round_robin_schedule_sim_unit_test NOT OK");
        $finish;
    end

endmodule
